### rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared constants for the stereo ring modulator: field widths, sine
// approximation coefficients, gain format and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

	localparam int DEFAULT_SINE_INDEX_BITS = 10;
	localparam int DEFAULT_SAMPLE_BITS     = 16;

	localparam int PHASE_BITS = 32;
	localparam int MIX_BITS   = 16;
	localparam int CFG_BITS   = 32;
	localparam int X_BITS     = 17;  // Q15 value in 0..32768 inclusive
	localparam int PROD_BITS  = 34;
	localparam int CARR_BITS  = 16;

	// Gain is Q2.30 signed: 1.0 == 2^30
	localparam int GAIN_BITS = 32;
	localparam int GAIN_FRAC = 30;

	localparam int SIN_A   = 51472;
	localparam int SIN_B   = 21024;
	localparam int SIN_C   = 2320;
	localparam int ONE_Q15 = 32768;

	// Carrier pipeline depth: settle count reloaded on a phase or mix change
	localparam int CARRIER_LAT = 6;
	localparam int SETTLE_BITS = $clog2(CARRIER_LAT + 1);

	typedef logic [0:0] reg_index_t;
	localparam reg_index_t REG_PHASE_STEP = 1'b0;
	localparam reg_index_t REG_MIX_LEVEL  = 1'b1;

endpackage

`default_nettype wire

### rtl/srm_carrier.sv
// ----------------------------------------------------------------------------
// srm_carrier
// Pipelined sine approximation of the carrier phase followed by the gain
// term 1 + mix*(carrier - 1) in Q2.30. Runs every cycle; CARRIER_LAT deep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_carrier
	import srm_pkg::*;
#(
	parameter int SINE_INDEX_BITS = DEFAULT_SINE_INDEX_BITS
) (
	input  wire logic                        clk,
	input  wire logic [PHASE_BITS-1:0]       phase,
	input  wire logic [MIX_BITS-1:0]         mix_level,
	output logic signed [GAIN_BITS-1:0]      gain
);

	localparam int RB     = SINE_INDEX_BITS - 2;
	localparam int XSHIFT = X_BITS - SINE_INDEX_BITS;
	localparam int MB     = GAIN_BITS + 3;

	logic [SINE_INDEX_BITS-1:0] idx;
	logic [RB-1:0]              r;
	logic [X_BITS-1:0]          x_raw;
	logic [X_BITS-1:0]          x_fold;

	assign idx    = phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
	assign r      = idx[RB-1:0];
	assign x_raw  = X_BITS'(r) << XSHIFT;
	// odd quadrants run the quarter wave backwards
	assign x_fold = idx[SINE_INDEX_BITS-2] ? (X_BITS'(ONE_Q15) - x_raw) : x_raw;

	// stage 1: folded argument
	logic [X_BITS-1:0] x_s1;
	logic              neg_s1;

	always_ff @(posedge clk) begin
		x_s1   <= x_fold;
		neg_s1 <= idx[SINE_INDEX_BITS-1];
	end

	// stage 2: x2 = x*x >> 15
	logic [PROD_BITS-1:0] sq_prod;
	logic [X_BITS-1:0]    x2_s2;
	logic [X_BITS-1:0]    x_s2;
	logic                 neg_s2;

	assign sq_prod = PROD_BITS'(x_s1) * PROD_BITS'(x_s1);

	always_ff @(posedge clk) begin
		x2_s2  <= sq_prod[15 +: X_BITS];
		x_s2   <= x_s1;
		neg_s2 <= neg_s1;
	end

	// stage 3: t1 = B - (C*x2 >> 15)
	logic [PROD_BITS-1:0] cx_prod;
	logic [18:0]          cx_sh;
	logic [15:0]          t1_s3;
	logic [X_BITS-1:0]    x2_s3;
	logic [X_BITS-1:0]    x_s3;
	logic                 neg_s3;

	assign cx_prod = PROD_BITS'(SIN_C) * PROD_BITS'(x2_s2);
	assign cx_sh   = cx_prod[33:15];

	always_ff @(posedge clk) begin
		t1_s3  <= 16'(19'(SIN_B) - cx_sh);
		x2_s3  <= x2_s2;
		x_s3   <= x_s2;
		neg_s3 <= neg_s2;
	end

	// stage 4: t2 = A - (t1*x2 >> 15)
	logic [PROD_BITS-1:0] tx_prod;
	logic [18:0]          tx_sh;
	logic [15:0]          t2_s4;
	logic [X_BITS-1:0]    x_s4;
	logic                 neg_s4;

	assign tx_prod = PROD_BITS'(t1_s3) * PROD_BITS'(x2_s3);
	assign tx_sh   = tx_prod[33:15];

	always_ff @(posedge clk) begin
		t2_s4  <= 16'(19'(SIN_A) - tx_sh);
		x_s4   <= x_s3;
		neg_s4 <= neg_s3;
	end

	// stage 5: y = t2*x >> 15, clamp, apply sign of the half period
	logic [PROD_BITS-1:0]        y_prod;
	logic [18:0]                 y_sh;
	logic [14:0]                 y_clamp;
	logic signed [CARR_BITS-1:0] y_pos;
	logic signed [CARR_BITS-1:0] carrier_s5;

	assign y_prod  = PROD_BITS'(t2_s4) * PROD_BITS'(x_s4);
	assign y_sh    = y_prod[33:15];
	assign y_clamp = (y_sh > 19'd32767) ? 15'h7fff : y_sh[14:0];
	assign y_pos   = $signed({1'b0, y_clamp});

	always_ff @(posedge clk) begin
		carrier_s5 <= neg_s4 ? -y_pos : y_pos;
	end

	// stage 6: gain = 2^30 + m*(c - 1.0)
	logic [MIX_BITS-1:0]  mix_clamp;
	logic signed [17:0]   c_minus_one;
	logic signed [MB-1:0] mix_prod;
	logic signed [MB-1:0] gain_sum;

	assign mix_clamp   = (mix_level > MIX_BITS'(ONE_Q15)) ? MIX_BITS'(ONE_Q15) : mix_level;
	assign c_minus_one = 18'(carrier_s5) - 18'sd32768;
	assign mix_prod    = $signed(MB'({1'b0, mix_clamp})) * MB'(c_minus_one);
	assign gain_sum    = mix_prod + (MB'(1) <<< GAIN_FRAC);

	always_ff @(posedge clk) begin
		gain <= GAIN_BITS'(gain_sum);
	end

endmodule

`default_nettype wire

### rtl/srm_lane.sv
// ----------------------------------------------------------------------------
// srm_lane
// One channel: sample times gain, then round half up and saturate to the
// signed sample range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_lane
	import srm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic signed [GAIN_BITS-1:0]   gain,
	output logic signed [SAMPLE_BITS-1:0]      result
);

	localparam int PB = SAMPLE_BITS + GAIN_BITS;
	localparam int QB = SAMPLE_BITS + 2;

	localparam logic signed [QB-1:0] SAT_HI = $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [QB-1:0] SAT_LO = $signed({3'b111, {(SAMPLE_BITS-1){1'b0}}});

	logic signed [PB-1:0] prod_s1;
	logic signed [PB-1:0] biased;
	logic signed [QB-1:0] rounded;

	// product held until the next transaction
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PB'(sample) * PB'(gain);
		end
	end

	assign biased  = prod_s1 + (PB'(1) <<< (GAIN_FRAC - 1));
	assign rounded = $signed(biased[GAIN_FRAC +: QB]);

	always_comb begin
		if (rounded > SAT_HI) begin
			result = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rounded < SAT_LO) begin
			result = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			result = rounded[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

### rtl/stereo_ring_modulator.sv
// Each lane registers its product on accept; the pair then moves to the
// output register once that is empty or not stalled. Input takes one stereo
// pair at a time and stalls until then and until the 6-stage carrier pipeline
// has refilled after the phase advance. A configuration write also holds off
// input for a refill. Reset (arst_n low, asynchronous) clears configuration,
// phase, busy and out_valid to zero and holds off input while the carrier fills.
// ----------------------------------------------------------------------------
// stereo_ring_modulator
// Stereo ring modulator: a phase accumulator drives a sine carrier whose
// gain term scales both channels in two parallel lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_ring_modulator
	import srm_pkg::*;
#(
	parameter int SINE_INDEX_BITS = DEFAULT_SINE_INDEX_BITS,
	parameter int SAMPLE_BITS     = DEFAULT_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [CFG_BITS-1:0]           cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic                          last_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out
);

	logic [PHASE_BITS-1:0]        phase_step_q;
	logic [MIX_BITS-1:0]          mix_level_q;
	logic [PHASE_BITS-1:0]        phase_q;
	logic [SETTLE_BITS-1:0]       settle_q;
	logic                         busy_q;
	logic                         out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;

	logic                         accept;
	logic                         transfer;
	logic signed [GAIN_BITS-1:0]  gain;
	logic signed [SAMPLE_BITS-1:0] left_res;
	logic signed [SAMPLE_BITS-1:0] right_res;

	assign in_stall = (settle_q != '0) || busy_q;
	assign accept   = in_valid && !in_stall;
	assign transfer = busy_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			mix_level_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_MIX_LEVEL:  mix_level_q  <= cfg_data[MIX_BITS-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			settle_q <= SETTLE_BITS'(CARRIER_LAT);
			busy_q   <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= last_sample ? '0 : phase_q + phase_step_q;
			end
			// gain must be recomputed whenever phase or mix changes
			if (accept || cfg_write) begin
				settle_q <= SETTLE_BITS'(CARRIER_LAT);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (transfer) begin
				busy_q <= 1'b0;
			end
		end
	end

	srm_carrier #(
		.SINE_INDEX_BITS(SINE_INDEX_BITS)
	) u_carrier (
		.clk       (clk),
		.phase     (phase_q),
		.mix_level (mix_level_q),
		.gain      (gain)
	);

	srm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_left (
		.clk    (clk),
		.load   (accept),
		.sample (left_in),
		.gain   (gain),
		.result (left_res)
	);

	srm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_right (
		.clk    (clk),
		.load   (accept),
		.sample (right_in),
		.gain   (gain),
		.result (right_res)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (transfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (transfer) begin
			left_q  <= left_res;
			right_q <= right_res;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

`default_nettype wire

### rtl/srm_chk.sv
// ----------------------------------------------------------------------------
// srm_chk
// Port-level checks for the stereo ring modulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_chk
	import srm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   cfg_write,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [SAMPLE_BITS-1:0] left_out,
	input wire logic [SAMPLE_BITS-1:0] right_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");

	// one transaction at a time: input closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while previous transaction in flight");

	// a register write makes the carrier refill before new input
	a_cfg_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> in_stall)
		else $error("input open right after configuration write");

	// carrier pipeline is empty out of reset
	a_reset_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input open while carrier pipeline fills after reset");

endmodule

bind stereo_ring_modulator srm_chk #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_srm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_write (cfg_write),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_out  (left_out),
	.right_out (right_out)
);

`default_nettype wire
